// File: rtl/adsr_pkg.sv
package adsr_pkg;

    // Default widths of the sample and time fields.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 24;

    // Gain is Q1.15: fifteen fraction bits, 16 bits hold 0..one.
    localparam int GAIN_FRAC = 15;
    localparam int GAIN_W    = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

    // Configuration register map.
    localparam int CFG_IDX_W = 3;
    localparam int SUSTAIN_W = 16;
    localparam int LEN_RESET = 48000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK   = 3'd0,
        REG_DECAY    = 3'd1,
        REG_RELEASE  = 3'd2,
        REG_DURATION = 3'd3,
        REG_SUSTAIN  = 3'd4
    } cfg_idx_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/adsr_if.sv
// Input channel: one stereo pair per transaction.
interface adsr_sample_if #(
    parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          restart;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output restart, output left_in, output right_in,
                    input ready);
    modport sink   (input valid, input restart, input left_in, input right_in,
                    output ready);
endinterface

// Output channel: one scaled stereo pair per transaction.
interface adsr_result_if #(
    parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          still_active;

    modport source (output valid, output left_out, output right_out,
                    output still_active, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input still_active, output ready);
endinterface

// Configuration write channel.
interface adsr_cfg_if #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [adsr_pkg::CFG_IDX_W-1:0] index;
    logic [TIME_BITS-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/adsr_cfg_regs.sv
module adsr_cfg_regs #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    adsr_cfg_if.sink                         cfg,
    output logic [TIME_BITS-1:0]             attack_samples,
    output logic [TIME_BITS-1:0]             decay_samples,
    output logic [TIME_BITS-1:0]             release_samples,
    output logic [TIME_BITS-1:0]             duration_samples,
    output logic [adsr_pkg::SUSTAIN_W-1:0]   sustain_level
);
    import adsr_pkg::*;

    logic [TIME_BITS-1:0] attack_reg;
    logic [TIME_BITS-1:0] decay_reg;
    logic [TIME_BITS-1:0] release_reg;
    logic [TIME_BITS-1:0] duration_reg;
    logic [SUSTAIN_W-1:0] sustain_reg;

    // Writes are taken every cycle.
    assign cfg.ready = 1'b1;

    // Register file; an index beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= TIME_BITS'(LEN_RESET);
            decay_reg    <= TIME_BITS'(LEN_RESET);
            release_reg  <= TIME_BITS'(LEN_RESET);
            duration_reg <= TIME_BITS'(LEN_RESET);
            sustain_reg  <= GAIN_ONE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_ATTACK:   attack_reg   <= cfg.data;
                REG_DECAY:    decay_reg    <= cfg.data;
                REG_RELEASE:  release_reg  <= cfg.data;
                REG_DURATION: duration_reg <= cfg.data;
                REG_SUSTAIN:  sustain_reg  <= cfg.data[SUSTAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign attack_samples   = attack_reg;
    assign decay_samples    = decay_reg;
    assign release_samples  = release_reg;
    assign duration_samples = duration_reg;
    assign sustain_level    = sustain_reg;

endmodule

// File: rtl/adsr_div_unit.sv
module adsr_div_unit #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [TIME_BITS+adsr_pkg::GAIN_FRAC-1:0]   numerator,
    input  logic [TIME_BITS-1:0]                       divisor,
    output logic [adsr_pkg::GAIN_FRAC-1:0]             quotient,
    output adsr_pkg::div_stat_t                        stat
);
    import adsr_pkg::*;

    localparam int CW = $clog2(GAIN_FRAC + 1);

    // Restoring divider, one quotient bit per cycle. The caller guarantees
    // numerator < divisor * 2^GAIN_FRAC and holds divisor while busy.
    logic [TIME_BITS-1:0] rem_reg,  rem_next;
    logic [GAIN_FRAC-1:0] low_reg,  low_next;
    logic [GAIN_FRAC-1:0] q_reg,    q_next;
    logic [CW-1:0]        cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS+1:0] diff;
    logic                 fits;

    // Shared subtract and compare.
    assign trial = {rem_reg, low_reg[GAIN_FRAC-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};
    assign fits  = !diff[TIME_BITS+1];

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numerator[TIME_BITS+GAIN_FRAC-1:GAIN_FRAC];
            low_next  = numerator[GAIN_FRAC-1:0];
            q_next    = '0;
            cnt_next  = CW'(GAIN_FRAC);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            low_next = {low_reg[GAIN_FRAC-2:0], 1'b0};
            q_next   = {q_reg[GAIN_FRAC-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef NO_ASSERTIONS
    // The step counter is live for the whole division.
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty step count");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < divisor)
        else $error("divider remainder reached the divisor");
`endif

endmodule

// File: rtl/adsr_envelope_stereo_core.sv
// ADSR envelope on a stereo stream. Each input transaction carries one
// stereo pair and a restart flag that clears the elapsed-sample counter
// first; the core picks a Q1.15 gain for the current count (attack, decay,
// release, then sustain), scales both channels by it with a floor shift,
// advances the saturating counter and returns one result transaction that
// also says whether the count is still below the note duration. A small
// sequencer drives one shared multiplier and one restoring divider. An item
// whose gain is the sustain level or a release end point goes from decode
// straight to scaling; in attack or release the divider runs first
// (15 steps, one quotient bit each), and decay first forms the drop product
// on the multiplier. Input is not taken while an item is in work; a
// finished result waits in an output register, so the next item can be
// accepted before it is taken. Configuration is written through its own
// channel; the user must write it only while the core is idle (not enforced).
module adsr_envelope_stereo_core #(
    parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = adsr_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    adsr_sample_if.sink   feed,
    adsr_result_if.source result,
    adsr_cfg_if.sink      cfg
);
    import adsr_pkg::*;

    localparam int AW = ((TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS) + 1;
    localparam int MW = GAIN_W + 1;
    localparam int PW = AW + MW;
    localparam int NW = TIME_BITS + GAIN_FRAC;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DECODE   = 8'b0000_0010,
        ST_MUL_DROP = 8'b0000_0100,
        ST_DIV_GO   = 8'b0000_1000,
        ST_DIV_WAIT = 8'b0001_0000,
        ST_SCALE_L  = 8'b0010_0000,
        ST_SCALE_R  = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    // Configuration registers.
    logic [TIME_BITS-1:0] attack_samples;
    logic [TIME_BITS-1:0] decay_samples;
    logic [TIME_BITS-1:0] release_samples;
    logic [TIME_BITS-1:0] duration_samples;
    logic [SUSTAIN_W-1:0] sustain_level;

    adsr_cfg_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .attack_samples   (attack_samples),
        .decay_samples    (decay_samples),
        .release_samples  (release_samples),
        .duration_samples (duration_samples),
        .sustain_level    (sustain_level)
    );

    // Sequencer and datapath registers.
    state_t                        state_reg,     state_next;
    logic [TIME_BITS-1:0]          elapsed_reg,   elapsed_next;
    logic [TIME_BITS-1:0]          t_reg,         t_next;
    logic signed [SAMPLE_BITS-1:0] left_reg,      left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg,     right_next;
    logic signed [PW-1:0]          prod_reg,      prod_next;
    logic [TIME_BITS-1:0]          divisor_reg,   divisor_next;
    logic [GAIN_W-1:0]             gain_reg,      gain_next;
    logic                          gain_sub_reg,  gain_sub_next;
    logic                          active_reg,    active_next;
    logic signed [SAMPLE_BITS-1:0] left_res_reg,  left_res_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg,  left_out_next;
    logic signed [SAMPLE_BITS-1:0] right_out_reg, right_out_next;
    logic                          still_reg,     still_next;
    logic                          out_valid_reg, out_valid_next;

    // Divider handshake.
    logic                 div_start;
    logic [GAIN_FRAC-1:0] div_q;
    div_stat_t            div_stat;

    adsr_div_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (prod_reg[NW-1:0]),
        .divisor   (divisor_reg),
        .quotient  (div_q),
        .stat      (div_stat)
    );

    // Phase decode on the current count.
    logic [GAIN_W-1:0]    sustain_eff;
    logic [GAIN_W-1:0]    sustain_gap;
    logic [TIME_BITS:0]   attack_decay_end;
    logic [TIME_BITS:0]   release_reach;
    logic                 in_attack;
    logic                 in_decay;
    logic                 in_release;
    logic                 below_len;
    logic [TIME_BITS-1:0] time_left;
    logic [TIME_BITS-1:0] time_in_decay;
    logic [TIME_BITS-1:0] t_inc;

    assign sustain_eff      = (sustain_level > GAIN_ONE) ? GAIN_ONE : sustain_level;
    assign sustain_gap      = GAIN_ONE - sustain_eff;
    assign attack_decay_end = {1'b0, attack_samples} + {1'b0, decay_samples};
    assign release_reach    = {1'b0, t_reg} + {1'b0, release_samples};
    assign in_attack        = t_reg < attack_samples;
    assign in_decay         = {1'b0, t_reg} < attack_decay_end;
    assign in_release       = release_reach >= {1'b0, duration_samples};
    assign below_len        = t_reg < duration_samples;
    assign time_left        = duration_samples - t_reg;
    assign time_in_decay    = t_reg - attack_samples;
    assign t_inc            = (&t_reg) ? t_reg : t_reg + TIME_BITS'(1);

    // Shared multiplier, operands chosen by the sequencer.
    logic signed [AW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL_DROP)
        begin
            mul_a = {{(AW-TIME_BITS){1'b0}}, time_in_decay};
            mul_b = {1'b0, sustain_gap};
        end
        else if (state_reg == ST_SCALE_L)
        begin
            mul_a = {{(AW-SAMPLE_BITS){left_reg[SAMPLE_BITS-1]}}, left_reg};
            mul_b = {1'b0, gain_reg};
        end
        else if (state_reg == ST_SCALE_R)
        begin
            mul_a = {{(AW-SAMPLE_BITS){right_reg[SAMPLE_BITS-1]}}, right_reg};
            mul_b = {1'b0, gain_reg};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Arithmetic shift right by the fraction bits, kept to the sample width.
    logic signed [SAMPLE_BITS-1:0] scaled;
    assign scaled = prod_reg[GAIN_FRAC +: SAMPLE_BITS];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        t_next         = t_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        prod_next      = prod_reg;
        divisor_next   = divisor_reg;
        gain_next      = gain_reg;
        gain_sub_next  = gain_sub_reg;
        active_next    = active_reg;
        left_res_next  = left_res_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        still_next     = still_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    t_next     = feed.restart ? '0 : elapsed_reg;
                    left_next  = feed.left_in;
                    right_next = feed.right_in;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                elapsed_next  = t_inc;
                active_next   = t_inc < duration_samples;
                gain_sub_next = 1'b0;
                if (in_attack)
                begin
                    prod_next    = {{(PW-NW){1'b0}}, t_reg, {GAIN_FRAC{1'b0}}};
                    divisor_next = attack_samples;
                    state_next   = ST_DIV_GO;
                end
                else if (in_decay)
                begin
                    divisor_next  = decay_samples;
                    gain_sub_next = 1'b1;
                    state_next    = ST_MUL_DROP;
                end
                else if (in_release)
                begin
                    if (release_samples == '0 || !below_len)
                    begin
                        gain_next  = '0;
                        state_next = ST_SCALE_L;
                    end
                    else if (time_left >= release_samples)
                    begin
                        gain_next  = GAIN_ONE;
                        state_next = ST_SCALE_L;
                    end
                    else
                    begin
                        prod_next    = {{(PW-NW){1'b0}}, time_left, {GAIN_FRAC{1'b0}}};
                        divisor_next = release_samples;
                        state_next   = ST_DIV_GO;
                    end
                end
                else
                begin
                    gain_next  = sustain_eff;
                    state_next = ST_SCALE_L;
                end
            end
            ST_MUL_DROP:
            begin
                prod_next  = mul_p;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    gain_next  = gain_sub_reg ? GAIN_ONE - {1'b0, div_q} : {1'b0, div_q};
                    state_next = ST_SCALE_L;
                end
            end
            ST_SCALE_L:
            begin
                prod_next  = mul_p;
                state_next = ST_SCALE_R;
            end
            ST_SCALE_R:
            begin
                left_res_next = scaled;
                prod_next     = mul_p;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    left_out_next  = left_res_reg;
                    right_out_next = scaled;
                    still_next     = active_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        prod_reg      <= prod_next;
        divisor_reg   <= divisor_next;
        gain_reg      <= gain_next;
        gain_sub_reg  <= gain_sub_next;
        active_reg    <= active_next;
        left_res_reg  <= left_res_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        still_reg     <= still_next;
    end

    // Channel outputs.
    assign feed.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.left_out     = left_out_reg;
    assign result.right_out    = right_out_reg;
    assign result.still_active = still_reg;

`ifndef NO_ASSERTIONS
    // An accepted transaction moves straight into phase decode.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (feed.valid && feed.ready) |=> state_reg == ST_DECODE)
        else $error("accepted item did not enter decode");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait state");

    // The divider is never restarted while a division is running.
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // The gain used for scaling never exceeds one.
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE_L) |-> gain_reg <= GAIN_ONE)
        else $error("gain above one");

    // Leaving the finish state always presents a result.
    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (!out_valid_reg || result.ready)) |=> out_valid_reg)
        else $error("finished item produced no result");
`endif

endmodule
